FILE: hw/rtl/esrc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the environmental sensor compensation block.
// Used by the serial multiplier, the serial divider and the top level.
package esrc_pkg;

  localparam int DIV_W = 40;

  localparam logic [1:0] OP_TEMP  = 2'd0;
  localparam logic [1:0] OP_PRESS = 2'd1;
  localparam logic [1:0] OP_HUM   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] CFG_TEMP       = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] CFG_PRESS_LAST = 3'd3;
  localparam logic [2:0] CFG_HUM        = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [19:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic signed [31:0] alt_value;
  } out_item_t;

endpackage

FILE: hw/rtl/env_sensor_raw_compensation.sv
`timescale 1ns / 1ps
// Top level of the environmental sensor compensation block: sequencer,
// calibration registers and output register. Uses esrc_pkg, esrc_ser_mul, esrc_ser_div.
//
// Each item carries a raw reading tagged temperature, pressure or humidity and
// yields one result; the unused tag is taken and yields nothing. Items are worked
// one at a time by a sequencer that drives one bit-serial multiplier and one
// bit-serial divider; a multiply runs until no set bit of its second operand is
// left. Temperature takes four multiplies and a divide, pressure up to ten
// multiplies and two divides, humidity eight multiplies. The next item is taken
// while a finished result still waits in the output register. Temperature also
// updates the stored fine temperature used by the other kinds.
module env_sensor_raw_compensation (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  esrc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output esrc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import esrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [19:0]        raw_r, raw_nxt;
  logic signed [31:0] fine_r, fine_nxt;
  logic signed [31:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt, rd_r, rd_nxt;
  logic [31:0]        re_r, re_nxt, dvs_r, dvs_nxt;
  logic               flag_r, flag_nxt, neg_r, neg_nxt;
  logic signed [31:0] res_val_r, res_val_nxt, res_alt_r, res_alt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [47:0] tc_r;
  logic [63:0] pcl_r, pch_r, hc_r;
  logic [15:0] pc9_r;

  logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  logic               mul_start, mul_done, div_start, div_done;
  logic [31:0]        mul_a, mul_b, mul_prod_w, div_d;
  logic [DIV_W-1:0]   div_n, div_q;
  logic signed [31:0] prod;

  logic               go0, act;
  logic [3:0]         cur_step;
  logic [1:0]         cur_kind;
  logic [19:0]        raw_cur;

  assign t1 = 32'(signed'({1'b0, tc_r[15:0]}));
  assign t2 = 32'(signed'(tc_r[31:16]));
  assign t3 = 32'(signed'(tc_r[47:32]));
  assign p1 = 32'(signed'({1'b0, pcl_r[15:0]}));
  assign p2 = 32'(signed'(pcl_r[31:16]));
  assign p3 = 32'(signed'(pcl_r[47:32]));
  assign p4 = 32'(signed'(pcl_r[63:48]));
  assign p5 = 32'(signed'(pch_r[15:0]));
  assign p6 = 32'(signed'(pch_r[31:16]));
  assign p7 = 32'(signed'(pch_r[47:32]));
  assign p8 = 32'(signed'(pch_r[63:48]));
  assign p9 = 32'(signed'(pc9_r));
  assign h1 = 32'(signed'({1'b0, hc_r[7:0]}));
  assign h2 = 32'(signed'(hc_r[23:8]));
  assign h3 = 32'(signed'({1'b0, hc_r[31:24]}));
  assign h4 = 32'(signed'(hc_r[43:32]));
  assign h5 = 32'(signed'(hc_r[55:44]));
  assign h6 = 32'(signed'(hc_r[63:56]));

  assign prod      = mul_prod_w;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign go0      = (state_r == ST_IDLE) && in_valid && (in_data.opcode != OP_NONE);
  assign act      = go0 || ((state_r == ST_BUSY) && (mul_done || div_done));
  assign cur_step = go0 ? 4'd0 : step_r;
  assign cur_kind = go0 ? in_data.opcode : kind_r;
  assign raw_cur  = go0 ? in_data.raw_sample : raw_r;

  esrc_ser_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod_w)
  );

  esrc_ser_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    logic signed [31:0] raw32, raw16, tv, v1, tmp, pv, hx, qh;
    logic signed [39:0] w40, m40;
    logic [31:0]        pp, pq;
    logic               last;
    raw32 = signed'({12'd0, raw_cur});
    raw16 = signed'({16'd0, raw_cur[15:0]});
    tv    = '0;
    v1    = '0;
    tmp   = '0;
    pv    = '0;
    hx    = '0;
    qh    = '0;
    w40   = '0;
    m40   = '0;
    pp    = '0;
    pq    = '0;
    last  = 1'b0;

    state_nxt     = state_r;
    step_nxt      = step_r;
    kind_nxt      = kind_r;
    raw_nxt       = raw_r;
    fine_nxt      = fine_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    rd_nxt        = rd_r;
    re_nxt        = re_r;
    dvs_nxt       = dvs_r;
    flag_nxt      = flag_r;
    neg_nxt       = neg_r;
    res_val_nxt   = res_val_r;
    res_alt_nxt   = res_alt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_n         = '0;
    div_d         = '0;

    if (go0) begin
      kind_nxt = in_data.opcode;
      raw_nxt  = in_data.raw_sample;
    end

    if (act) begin
      case (cur_kind)
        OP_TEMP: begin
          case (cur_step)
            4'd0: begin
              mul_start = 1'b1;
              mul_a = (raw32 >>> 3) - (t1 <<< 1);
              mul_b = t2;
            end
            4'd1: begin
              rb_nxt = prod >>> 11;
              mul_start = 1'b1;
              mul_a = (raw32 >>> 4) - t1;
              mul_b = (raw32 >>> 4) - t1;
            end
            4'd2: begin
              mul_start = 1'b1;
              mul_a = prod >>> 12;
              mul_b = t3;
            end
            4'd3: begin
              tmp = rb_r + (prod >>> 14);
              fine_nxt = tmp;
              mul_start = 1'b1;
              mul_a = tmp;
              mul_b = 32'd5;
            end
            4'd4: begin
              tv = (prod + 32'sd128) >>> 8;
              res_val_nxt = tv;
              w40 = 40'(tv);
              m40 = (w40 <<< 3) + w40;
              neg_nxt = tv[31];
              div_start = 1'b1;
              div_n = tv[31] ? -m40 : m40;
              div_d = 32'd5;
            end
            default: begin
              pq = div_q[31:0];
              res_alt_nxt = (neg_r ? -signed'(pq) : signed'(pq)) + 32'sd3200;
              last = 1'b1;
            end
          endcase
        end
        OP_PRESS: begin
          case (cur_step)
            4'd0: begin
              v1 = (fine_r >>> 1) - 32'sd64000;
              ra_nxt = v1;
              mul_start = 1'b1;
              mul_a = v1 >>> 2;
              mul_b = v1 >>> 2;
            end
            4'd1: begin
              rb_nxt = prod;
              mul_start = 1'b1;
              mul_a = prod >>> 11;
              mul_b = p6;
            end
            4'd2: begin
              rc_nxt = prod;
              mul_start = 1'b1;
              mul_a = ra_r;
              mul_b = p5;
            end
            4'd3: begin
              rc_nxt = rc_r + (prod <<< 1);
              mul_start = 1'b1;
              mul_a = p3;
              mul_b = rb_r >>> 13;
            end
            4'd4: begin
              rc_nxt = (rc_r >>> 2) + (p4 <<< 16);
              rd_nxt = prod >>> 3;
              mul_start = 1'b1;
              mul_a = p2;
              mul_b = ra_r;
            end
            4'd5: begin
              tmp = (rd_r + (prod >>> 1)) >>> 18;
              mul_start = 1'b1;
              mul_a = tmp + 32'sd32768;
              mul_b = p1;
            end
            4'd6: begin
              v1 = prod >>> 15;
              if (v1 == 32'sd0) begin
                res_val_nxt = 32'sd30000;
                res_alt_nxt = 32'sd886;
                last = 1'b1;
              end else begin
                dvs_nxt = v1;
                mul_start = 1'b1;
                mul_a = 32'sd1048576 - raw32 - (rc_r >>> 12);
                mul_b = 32'd3125;
              end
            end
            4'd7: begin
              pp = prod;
              flag_nxt = pp[31];
              div_start = 1'b1;
              div_n = pp[31] ? {8'd0, pp} : {7'd0, pp, 1'b0};
              div_d = dvs_r;
            end
            4'd8: begin
              pq = flag_r ? {div_q[30:0], 1'b0} : div_q[31:0];
              re_nxt = pq;
              mul_start = 1'b1;
              mul_a = {3'd0, pq[31:3]};
              mul_b = {3'd0, pq[31:3]};
            end
            4'd9: begin
              mul_start = 1'b1;
              mul_a = p9;
              mul_b = {13'd0, prod[31:13]};
            end
            4'd10: begin
              rd_nxt = prod >>> 12;
              mul_start = 1'b1;
              mul_a = {2'd0, re_r[31:2]};
              mul_b = p8;
            end
            4'd11: begin
              pv = signed'(re_r) + ((rd_r + (prod >>> 13) + p7) >>> 4);
              res_val_nxt = pv;
              w40 = 40'(pv);
              m40 = (w40 <<< 6) + (w40 <<< 5) + (w40 <<< 2);
              neg_nxt = pv[31];
              div_start = 1'b1;
              div_n = pv[31] ? -m40 : m40;
              div_d = 32'd3386;
            end
            default: begin
              pq = div_q[31:0];
              res_alt_nxt = neg_r ? -signed'(pq) : signed'(pq);
              last = 1'b1;
            end
          endcase
        end
        default: begin
          case (cur_step)
            4'd0: begin
              v1 = fine_r - 32'sd76800;
              ra_nxt = v1;
              mul_start = 1'b1;
              mul_a = h5;
              mul_b = v1;
            end
            4'd1: begin
              rb_nxt = ((raw16 <<< 14) - (h4 <<< 20) - prod + 32'sd16384) >>> 15;
              mul_start = 1'b1;
              mul_a = ra_r;
              mul_b = h6;
            end
            4'd2: begin
              rc_nxt = prod >>> 10;
              mul_start = 1'b1;
              mul_a = ra_r;
              mul_b = h3;
            end
            4'd3: begin
              mul_start = 1'b1;
              mul_a = rc_r;
              mul_b = (prod >>> 11) + 32'sd32768;
            end
            4'd4: begin
              mul_start = 1'b1;
              mul_a = (prod >>> 10) + 32'sd2097152;
              mul_b = h2;
            end
            4'd5: begin
              mul_start = 1'b1;
              mul_a = rb_r;
              mul_b = (prod + 32'sd8192) >>> 14;
            end
            4'd6: begin
              rc_nxt = prod;
              mul_start = 1'b1;
              mul_a = prod >>> 15;
              mul_b = prod >>> 15;
            end
            4'd7: begin
              mul_start = 1'b1;
              mul_a = prod >>> 7;
              mul_b = h1;
            end
            default: begin
              hx = rc_r - (prod >>> 4);
              if (hx < 32'sd0) begin
                hx = 32'sd0;
              end
              if (hx > 32'sd419430400) begin
                hx = 32'sd419430400;
              end
              qh = hx >>> 12;
              res_alt_nxt = qh;
              res_val_nxt = ((qh <<< 6) + (qh <<< 5) + (qh <<< 2)) >>> 10;
              last = 1'b1;
            end
          endcase
        end
      endcase
      if (last) begin
        state_nxt = ST_DONE;
      end else begin
        state_nxt = ST_BUSY;
        step_nxt  = cur_step + 4'd1;
      end
    end

    if ((state_r == ST_DONE) && !(out_valid_r && out_stall)) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.kind      = kind_r;
      out_data_nxt.value     = res_val_r;
      out_data_nxt.alt_value = res_alt_r;
      state_nxt              = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
      fine_r      <= '0;
      tc_r        <= '0;
      pcl_r       <= '0;
      pch_r       <= '0;
      pc9_r       <= '0;
      hc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      fine_r      <= fine_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEMP:       tc_r  <= cfg_data[47:0];
          CFG_PRESS_LOW:  pcl_r <= cfg_data;
          CFG_PRESS_HIGH: pch_r <= cfg_data;
          CFG_PRESS_LAST: pc9_r <= cfg_data[15:0];
          CFG_HUM:        hc_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    kind_r     <= kind_nxt;
    raw_r      <= raw_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    rc_r       <= rc_nxt;
    rd_r       <= rd_nxt;
    re_r       <= re_nxt;
    dvs_r      <= dvs_nxt;
    flag_r     <= flag_nxt;
    neg_r      <= neg_nxt;
    res_val_r  <= res_val_nxt;
    res_alt_r  <= res_alt_nxt;
    out_data_r <= out_data_nxt;
  end

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done || div_done) |-> (state_r == ST_BUSY))
    else $error("arithmetic unit finished outside a computation");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> (step_r <= 4'd12))
    else $error("sequencer step out of range");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && out_stall |=> (state_r == ST_DONE))
    else $error("finished result dropped while output was stalled");

endmodule

FILE: hw/rtl/esrc_ser_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier giving the low 32 bits of a product.
// Uses esrc_pkg; one bit of the second operand is consumed per cycle.
module esrc_ser_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] prod
);
  import esrc_pkg::*;

  logic        busy_r, busy_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] acc_r, acc_nxt;

  assign done = busy_r && (b_r == 32'd0);
  assign prod = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = 32'd0;
    end else if (busy_r) begin
      if (b_r == 32'd0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = {a_r[30:0], 1'b0};
        b_nxt = {1'b0, b_r[31:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule

FILE: hw/rtl/esrc_ser_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, unsigned dividend by unsigned 32-bit divisor.
// Uses esrc_pkg for the dividend width; one quotient bit per cycle.
module esrc_ser_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [esrc_pkg::DIV_W-1:0]     dividend,
  input  logic [31:0]                    divisor,
  output logic                           done,
  output logic [esrc_pkg::DIV_W-1:0]     quotient
);
  import esrc_pkg::*;

  localparam int CntW = $clog2(DIV_W + 1);

  logic             busy_r, busy_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0] n_r, n_nxt;
  logic [31:0]      d_r, d_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [32:0]      trial;

  assign done     = busy_r && (cnt_r == CntW'(0));
  assign quotient = n_r;
  assign trial    = {rem_r, n_r[DIV_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(DIV_W);
      n_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = 32'd0;
    end else if (busy_r) begin
      if (cnt_r == CntW'(0)) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CntW'(1);
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = 32'(trial - {1'b0, d_r});
          n_nxt   = {n_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          n_nxt   = {n_r[DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

endmodule
